// ----- src/teletype_console_iot_device_core_assert.svh -----
// Assertion helpers, clocked on clk and held off while arst_n is low.
`ifndef TELETYPE_CONSOLE_IOT_DEVICE_CORE_ASSERT_SVH
`define TELETYPE_CONSOLE_IOT_DEVICE_CORE_ASSERT_SVH

// Same-cycle implication.
`define TCID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcid assertion failed");

// Next-cycle implication.
`define TCID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcid assertion failed");

`endif

// ----- src/tcid_pkg.sv -----
package tcid_pkg;

	localparam int AC_W    = 12;
	localparam int CHAR_W  = 8;
	localparam int PCHAR_W = 7;
	localparam int DELAY_W = 10;
	localparam int CFG_IDX_W = 2;

	// command codes
	localparam logic [1:0] CMD_IOT  = 2'd0;
	localparam logic [1:0] CMD_KEY  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// device select
	localparam logic DEV_KBD = 1'b0;
	localparam logic DEV_PRT = 1'b1;

	// low three bits of the I/O instruction
	localparam logic [2:0] FN_CLEAR_SET   = 3'd0;
	localparam logic [2:0] FN_SKIP        = 3'd1;
	localparam logic [2:0] FN_CLEAR       = 3'd2;
	localparam logic [2:0] FN_TRANSFER    = 3'd4;
	localparam logic [2:0] FN_ENABLE_SKIP = 3'd5;
	localparam logic [2:0] FN_COMBINED    = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRINT_DELAY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KBD_READY_DELAY = 2'd1;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd20;
	localparam logic [CHAR_W-1:0]  KBD_BIT8    = 8'o200;

	typedef struct packed {
		logic [AC_W-1:0]    ac_out;
		logic               ac_write;
		logic               skip;
		logic               print_valid;
		logic [PCHAR_W-1:0] print_char;
		logic               interrupt_request;
		logic               kbd_busy;
		logic               key_ready;
	} result_t;

	// a zero delay counts as one tick
	function automatic logic [DELAY_W-1:0] load_delay(input logic [DELAY_W-1:0] d);
		return (d == '0) ? DELAY_W'(1) : d;
	endfunction

endpackage

// ----- src/teletype_console_iot_device_core.sv -----
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------------------
// request  | in_valid  | in_stall  | command device_select iot_function ac_in kbd_char
// result   | out_valid | out_stall | ac_out ac_write skip print_valid print_char
//          |           |           | interrupt_request kbd_busy key_ready
// config   | cfg_we    | -         | cfg_index cfg_data
//
// One request per cycle sustained while the result register is not held full by out_stall; a
// request passes through the input register, then the flag/timer update into the result register.
// arst_n clears flags, timers and handshake state; int_enable resets to 1, delays to 20.
// in_stall rises only when a request sits in the input register and the result
// register is full and stalled.
`include "teletype_console_iot_device_core_assert.svh"

module teletype_console_iot_device_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic                              device_select,
	input  logic [2:0]                        iot_function,
	input  logic [tcid_pkg::AC_W-1:0]         ac_in,
	input  logic [tcid_pkg::CHAR_W-1:0]       kbd_char,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcid_pkg::AC_W-1:0]         ac_out,
	output logic                              ac_write,
	output logic                              skip,
	output logic                              print_valid,
	output logic [tcid_pkg::PCHAR_W-1:0]      print_char,
	output logic                              interrupt_request,
	output logic                              kbd_busy,
	output logic                              key_ready,
	input  logic                              cfg_we,
	input  logic [tcid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcid_pkg::DELAY_W-1:0]      cfg_data
);
	import tcid_pkg::*;

	// input register
	logic                s1_valid_q;
	logic [1:0]          command_s1;
	logic                device_s1;
	logic [2:0]          fn_s1;
	logic [AC_W-1:0]     ac_s1;
	logic [CHAR_W-1:0]   char_s1;

	// device state
	logic [DELAY_W-1:0]  print_delay_q, kbd_ready_delay_q;
	logic                kbd_flag_q, prt_flag_q, int_enable_q;
	logic [CHAR_W-1:0]   kbd_store_q;
	logic [DELAY_W-1:0]  print_timer_q, kbd_timer_q;

	logic                kbd_flag_d, prt_flag_d, int_enable_d;
	logic [CHAR_W-1:0]   kbd_store_d;
	logic [DELAY_W-1:0]  print_timer_d, kbd_timer_d;

	// result register
	logic                out_valid_q;
	result_t             res_d, res_q;

	logic out_free, s1_adv, in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_take || (s1_valid_q && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1 <= command;
			device_s1  <= device_select;
			fn_s1      <= iot_function;
			ac_s1      <= ac_in;
			char_s1    <= kbd_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			print_delay_q     <= DELAY_RESET;
			kbd_ready_delay_q <= DELAY_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_PRINT_DELAY)
				print_delay_q <= cfg_data;
			else if (cfg_index == REG_KBD_READY_DELAY)
				kbd_ready_delay_q <= cfg_data;
		end
	end

	always_comb begin
		kbd_flag_d    = kbd_flag_q;
		prt_flag_d    = prt_flag_q;
		int_enable_d  = int_enable_q;
		kbd_store_d   = kbd_store_q;
		print_timer_d = print_timer_q;
		kbd_timer_d   = kbd_timer_q;
		res_d         = '0;

		case (command_s1)
			CMD_IOT: begin
				if (device_s1 == DEV_KBD) begin
					case (fn_s1)
						FN_CLEAR_SET: begin
							kbd_flag_d  = 1'b0;
							kbd_timer_d = load_delay(kbd_ready_delay_q);
						end
						FN_SKIP: res_d.skip = kbd_flag_q;
						FN_CLEAR: begin
							kbd_flag_d     = 1'b0;
							res_d.ac_write = 1'b1;
							kbd_timer_d    = load_delay(kbd_ready_delay_q);
						end
						FN_TRANSFER: begin
							res_d.ac_out   = ac_s1 | AC_W'(kbd_store_q);
							res_d.ac_write = 1'b1;
						end
						FN_ENABLE_SKIP: int_enable_d = ac_s1[0];
						FN_COMBINED: begin
							kbd_flag_d     = 1'b0;
							res_d.ac_out   = AC_W'(kbd_store_q);
							res_d.ac_write = 1'b1;
							kbd_timer_d    = load_delay(kbd_ready_delay_q);
						end
						default: ;
					endcase
				end else begin
					case (fn_s1)
						FN_CLEAR_SET: prt_flag_d = 1'b1;
						FN_SKIP:      res_d.skip = prt_flag_q;
						FN_CLEAR:     prt_flag_d = 1'b0;
						FN_TRANSFER: begin
							res_d.print_valid = 1'b1;
							res_d.print_char  = ac_s1[PCHAR_W-1:0];
							print_timer_d     = load_delay(print_delay_q);
						end
						FN_ENABLE_SKIP: res_d.skip = (kbd_flag_q || prt_flag_q) && int_enable_q;
						FN_COMBINED: begin
							prt_flag_d        = 1'b0;
							res_d.print_valid = 1'b1;
							res_d.print_char  = ac_s1[PCHAR_W-1:0];
							print_timer_d     = load_delay(print_delay_q);
						end
						default: ;
					endcase
				end
			end
			CMD_KEY: begin
				if (kbd_flag_q) begin
					res_d.kbd_busy = 1'b1;
				end else begin
					kbd_store_d = char_s1 | KBD_BIT8;
					kbd_flag_d  = 1'b1;
				end
			end
			CMD_TICK: begin
				// each running timer fires in the tick that brings it to zero
				if (print_timer_q != '0) begin
					print_timer_d = print_timer_q - 1'b1;
					if (print_timer_q == DELAY_W'(1))
						prt_flag_d = 1'b1;
				end
				if (kbd_timer_q != '0) begin
					kbd_timer_d = kbd_timer_q - 1'b1;
					if (kbd_timer_q == DELAY_W'(1))
						res_d.key_ready = 1'b1;
				end
			end
			default: ;
		endcase

		res_d.interrupt_request = (kbd_flag_d || prt_flag_d) && int_enable_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbd_flag_q    <= 1'b0;
			prt_flag_q    <= 1'b0;
			int_enable_q  <= 1'b1;
			kbd_store_q   <= '0;
			print_timer_q <= '0;
			kbd_timer_q   <= '0;
		end else if (s1_adv) begin
			kbd_flag_q    <= kbd_flag_d;
			prt_flag_q    <= prt_flag_d;
			int_enable_q  <= int_enable_d;
			kbd_store_q   <= kbd_store_d;
			print_timer_q <= print_timer_d;
			kbd_timer_q   <= kbd_timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= s1_adv || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			res_q <= res_d;
	end

	assign out_valid         = out_valid_q;
	assign ac_out            = res_q.ac_out;
	assign ac_write          = res_q.ac_write;
	assign skip              = res_q.skip;
	assign print_valid       = res_q.print_valid;
	assign print_char        = res_q.print_char;
	assign interrupt_request = res_q.interrupt_request;
	assign kbd_busy          = res_q.kbd_busy;
	assign key_ready         = res_q.key_ready;

	`TCID_ASSERT_NOW(a_stall_needs_held_request, in_stall, s1_valid_q && out_valid_q)
	`TCID_ASSERT_NOW(a_busy_is_alone, out_valid && kbd_busy, !ac_write && !print_valid && !skip)
	`TCID_ASSERT_NEXT(a_print_arms_timer,
		s1_adv && command_s1 == CMD_IOT && device_s1 == DEV_PRT &&
		(fn_s1 == FN_TRANSFER || fn_s1 == FN_COMBINED),
		print_timer_q != '0)

endmodule
